// ===== sv/trie_word_break_checker_defines.svh =====
// Assertion macros for the checker file of the word-break block.
`ifndef TRIE_WORD_BREAK_CHECKER_DEFINES_SVH
`define TRIE_WORD_BREAK_CHECKER_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define TWB_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define TWB_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/twb_pkg.sv =====
package twb_pkg;

  // Size of the trie node table, root included.
  localparam int NODES = 256;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = IDX_W + 1;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_EMPTY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // One node table entry.
  typedef struct packed {
    logic             word_end;
    logic [IDX_W-1:0] parent;
    logic [7:0]       sym;
  } node_t;

  // Write controls for the active-set banks.
  typedef struct packed {
    logic             wr_next;
    logic             clr_both;
    logic [IDX_W-1:0] waddr;
    logic             wbit;
  } act_ctl_t;

endpackage

// ===== sv/twb_node_store.sv =====
module twb_node_store import twb_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  node_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output node_t            rdata
);

  // Node table: parent, byte and word-end mark of each node.
  node_t mem [NODES];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/twb_active_store.sv =====
module twb_active_store import twb_pkg::*; (
  input  logic             clk,
  input  act_ctl_t         ctl,
  input  logic             cur_bank,
  input  logic [IDX_W-1:0] raddr,
  output logic             rdata
);

  // Two banks: the current active set is read while the next one is written.
  logic bank0 [NODES];
  logic bank1 [NODES];
  logic rd0;
  logic rd1;
  logic sel;

  // Bank 0 is the next set when bank 1 is current; a new node clears both.
  always_ff @(posedge clk) begin
    if (ctl.clr_both || (ctl.wr_next && cur_bank)) begin
      bank0[ctl.waddr] <= ctl.clr_both ? 1'b0 : ctl.wbit;
    end
    rd0 <= bank0[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_both || (ctl.wr_next && !cur_bank)) begin
      bank1[ctl.waddr] <= ctl.clr_both ? 1'b0 : ctl.wbit;
    end
    rd1 <= bank1[raddr];
    sel <= cur_bank;
  end

  // Pick the bit of the bank that was current when the read was issued.
  assign rdata = sel ? rd1 : rd0;

endmodule

// ===== sv/trie_word_break_checker.sv =====
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+------------------------
// request   | cmd[1:0], ch[7:0], last                 | start high, busy low
// result    | segmentable, insert_overflow            | done high for one cycle
//
// An insert or query byte holds busy for one pass of the scan pipeline over the
// node table, one entry per cycle, then the pipeline drain and the finish state.
// A discarded word byte and an empty query do not raise busy. Reset is synchronous
// and leaves only the root in the table; requests are taken at once after it.
// The result strobe cannot be held off, and busy stays high until the byte is done.
module trie_word_break_checker import twb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       busy,
  output logic       done,
  output logic       segmentable,
  output logic       insert_overflow
);

  state_t           state;
  state_t           state_next;
  logic             is_query;
  logic [7:0]       ch_r;
  logic             last_r;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] nodes_used;
  logic [IDX_W-1:0] cursor;
  logic             drop;
  logic             overflow_seen;
  logic             fresh;
  logic             cur_bank;
  logic             s1_v;
  logic             s2_v;
  logic [IDX_W-1:0] s1_idx;
  logic [IDX_W-1:0] s2_idx;
  logic             s2_sym_eq;
  logic             s2_end;
  logic             s2_root;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             seg;
  node_t            node_rd;
  node_t            node_wdata;
  logic             node_we;
  logic [IDX_W-1:0] node_waddr;
  act_ctl_t         act_ctl;
  logic             act_rd;
  logic             accept;
  logic             issue;
  logic             drained;
  logic             full;
  logic             hit;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign issue   = (state == S_SCAN) && (idx < nodes_used);
  assign drained = !issue && !s1_v && !s2_v;
  assign full    = (nodes_used == CNT_W'(NODES));

  // A node follows the query byte if its byte matches and its parent was active.
  // Straight after a finished query only the root is active.
  assign hit = s2_v && is_query && s2_sym_eq && (fresh ? s2_root : act_rd);

  twb_node_store u_nodes (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (node_rd)
  );

  twb_active_store u_active (
    .clk      (clk),
    .ctl      (act_ctl),
    .cur_bank (cur_bank),
    .raddr    (node_rd.parent),
    .rdata    (act_rd)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a query byte or a kept insert byte scans the table.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd == CMD_QUERY || (cmd == CMD_INSERT && !drop))) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (drained) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Node table writes: set the end mark on a found node or append a new one.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = found_idx;
    node_wdata = '{word_end: 1'b1, parent: cursor, sym: ch_r};
    if (state == S_FINISH && !is_query) begin
      if (found) begin
        node_we = last_r;
      end else if (!full) begin
        node_we             = 1'b1;
        node_waddr          = nodes_used[IDX_W-1:0];
        node_wdata.word_end = last_r;
      end
    end
  end

  // Active-set writes: for a query, each scanned node and then the root into the next bank; a new node clears both.
  always_comb begin
    act_ctl = '0;
    if (s2_v && is_query) begin
      act_ctl.wr_next = 1'b1;
      act_ctl.waddr   = s2_idx;
      act_ctl.wbit    = hit;
    end
    if (state == S_FINISH) begin
      if (is_query) begin
        act_ctl.wr_next = 1'b1;
        act_ctl.waddr   = '0;
        act_ctl.wbit    = seg;
      end else if (!found && !full) begin
        act_ctl.clr_both = 1'b1;
        act_ctl.waddr    = nodes_used[IDX_W-1:0];
      end
    end
  end

  // Scan pipeline payload.
  always_ff @(posedge clk) begin
    s1_idx    <= idx[IDX_W-1:0];
    s2_idx    <= s1_idx;
    s2_sym_eq <= (node_rd.sym == ch_r);
    s2_end    <= node_rd.word_end;
    s2_root   <= (node_rd.parent == '0);
  end

  // Control and trie bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= CNT_W'(1);
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      nodes_used    <= CNT_W'(1);
      cursor        <= '0;
      drop          <= 1'b0;
      overflow_seen <= 1'b0;
      fresh         <= 1'b1;
      cur_bank      <= 1'b0;
      done          <= 1'b0;
      found         <= 1'b0;
      seg           <= 1'b0;
      is_query      <= 1'b0;
    end else begin
      done <= 1'b0;
      s1_v <= issue;
      s2_v <= s1_v;
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end

      // Take a request.
      if (accept) begin
        ch_r     <= ch;
        last_r   <= last;
        idx      <= CNT_W'(1);
        found    <= 1'b0;
        seg      <= 1'b0;
        is_query <= (cmd == CMD_QUERY);
        if (cmd == CMD_EMPTY) begin
          done            <= 1'b1;
          segmentable     <= 1'b1;
          insert_overflow <= overflow_seen;
          fresh           <= 1'b1;
        end
        if (cmd == CMD_INSERT && drop && last) begin
          drop   <= 1'b0;
          cursor <= '0;
        end
      end

      // Insert search: the child of the cursor with this byte.
      if (s1_v && !is_query && node_rd.parent == cursor && node_rd.sym == ch_r) begin
        found     <= 1'b1;
        found_idx <= s1_idx;
      end

      // Query: any matched node that ends a word lets the next word start.
      if (hit && s2_end) begin
        seg <= 1'b1;
      end

      // Close the byte.
      if (state == S_FINISH) begin
        if (is_query) begin
          if (last_r) begin
            done            <= 1'b1;
            segmentable     <= seg;
            insert_overflow <= overflow_seen;
            fresh           <= 1'b1;
          end else begin
            fresh    <= 1'b0;
            cur_bank <= !cur_bank;
          end
        end else if (found) begin
          cursor <= last_r ? '0 : found_idx;
        end else if (!full) begin
          nodes_used <= nodes_used + CNT_W'(1);
          cursor     <= last_r ? '0 : nodes_used[IDX_W-1:0];
        end else begin
          overflow_seen <= 1'b1;
          drop          <= !last_r;
          if (last_r) begin
            cursor <= '0;
          end
        end
      end
    end
  end

endmodule

// ===== sv/twb_checker.sv =====
`include "trie_word_break_checker_defines.svh"

module twb_checker import twb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic [1:0] cmd,
  input logic       busy,
  input logic       done,
  input logic       segmentable
);

  // A result only appears once the byte that caused it is fully handled.
  `TWB_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy, "result strobe while busy")

  // A query byte always walks the node table.
  `TWB_ASSERT_NXT(a_query_busy, clk, rst, start && !busy && cmd == CMD_QUERY, busy, "query byte did not start a scan")

  // The empty string always splits, answered in the next cycle.
  `TWB_ASSERT_NXT(a_empty_true, clk, rst, start && !busy && cmd == CMD_EMPTY, done && segmentable, "empty query not answered true")

  // The unused command leaves the block quiet.
  `TWB_ASSERT_NXT(a_unused_quiet, clk, rst, start && !busy && cmd == CMD_NONE, !done && !busy, "unused command had an effect")

endmodule

bind trie_word_break_checker twb_checker u_twb_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .cmd         (cmd),
  .busy        (busy),
  .done        (done),
  .segmentable (segmentable)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import twb_pkg::*;

  localparam int TARGET_REQUESTS = 550;
  localparam int FILL_AFTER      = 250;
  localparam int LIMIT_CYCLES    = 1000000;

  // One request as presented on the request ports.
  typedef struct packed {
    cmd_t       op;
    logic [7:0] sym;
    logic       fin;
  } request_t;

  // One answer as seen on the result ports.
  typedef struct packed {
    logic seg;
    logic ovf;
  } answer_t;

  // A dictionary word of up to sixteen bytes.
  typedef struct packed {
    logic [4:0]       len;
    logic [15:0][7:0] b;
  } word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] cmd = CMD_NONE;
  logic [7:0] ch = 8'h00;
  logic       last = 1'b0;
  logic       busy;
  logic       done;
  logic       segmentable;
  logic       insert_overflow;

  trie_word_break_checker uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .cmd             (cmd),
    .ch              (ch),
    .last            (last),
    .busy            (busy),
    .done            (done),
    .segmentable     (segmentable),
    .insert_overflow (insert_overflow)
  );

  always #5 clk = ~clk;

  request_t pending_requests[$];
  answer_t  answers_due[$];
  word_t    dictionary[$];

  int errors      = 0;
  int cycles      = 0;
  int n_queued    = 0;
  int n_accepted  = 0;
  int n_inserts   = 0;
  int n_queries   = 0;
  int n_ignored   = 0;
  int n_answers   = 0;
  int n_true      = 0;
  int n_ovf_seen  = 0;

  // Predicted trie: node table, word-end marks, active set and insert state.
  int                 tr_parent [NODES];
  logic [7:0]         tr_sym [NODES];
  logic [NODES-1:0]   tr_end = '0;
  logic [NODES-1:0]   tr_active = NODES'(1);
  int                 tr_used = 1;
  int                 tr_cursor = 0;
  logic               tr_ovf = 1'b0;
  logic               tr_drop = 1'b0;

  // Shadow of the node count, kept while requests are generated.
  int   gen_child [int];
  int   gen_used = 1;
  int   gen_cursor = 0;
  bit   gen_drop = 1'b0;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Apply one accepted request to the predicted trie and record any answer due.
  task automatic predict_request(request_t r);
    int               i;
    int               found;
    logic             hit;
    logic [NODES-1:0] reach;
    case (r.op)
      CMD_INSERT: begin
        n_inserts++;
        if (!tr_drop) begin
          found = 0;
          for (i = 1; i < tr_used; i++) begin
            if (tr_parent[i] == tr_cursor && tr_sym[i] == r.sym) begin
              found = i;
              break;
            end
          end
          if (found == 0) begin
            if (tr_used < NODES) begin
              found = tr_used;
              tr_parent[found] = tr_cursor;
              tr_sym[found] = r.sym;
              tr_end[found] = 1'b0;
              tr_used++;
            end else begin
              tr_ovf = 1'b1;
              tr_drop = 1'b1;
            end
          end
          if (!tr_drop) begin
            tr_cursor = found;
            if (r.fin) tr_end[found] = 1'b1;
          end
        end
        if (r.fin) begin
          tr_cursor = 0;
          tr_drop = 1'b0;
        end
      end
      CMD_QUERY: begin
        n_queries++;
        hit = 1'b0;
        reach = '0;
        for (i = 1; i < tr_used; i++) begin
          if (tr_sym[i] == r.sym && tr_active[tr_parent[i]]) begin
            reach[i] = 1'b1;
            if (tr_end[i]) hit = 1'b1;
          end
        end
        reach[0] = hit;
        tr_active = reach;
        if (r.fin) begin
          tr_active = NODES'(1);
          answers_due.push_back('{seg: hit, ovf: tr_ovf});
        end
      end
      CMD_EMPTY: begin
        n_queries++;
        tr_active = NODES'(1);
        answers_due.push_back('{seg: 1'b1, ovf: tr_ovf});
      end
      default: n_ignored++;
    endcase
  endtask

  // Queue one request and keep the shadow node count in step.
  task automatic queue_request(cmd_t op, logic [7:0] sym, logic fin);
    int key;
    pending_requests.push_back('{op: op, sym: sym, fin: fin});
    if (op != CMD_NONE) n_queued++;
    if (op == CMD_INSERT) begin
      if (!gen_drop) begin
        key = gen_cursor * 256 + sym;
        if (gen_child.exists(key)) gen_cursor = gen_child[key];
        else if (gen_used < NODES) begin
          gen_child[key] = gen_used;
          gen_cursor = gen_used;
          gen_used++;
        end else gen_drop = 1'b1;
      end
      if (fin) begin
        gen_cursor = 0;
        gen_drop = 1'b0;
      end
    end
  endtask

  task automatic queue_word(cmd_t op, word_t w);
    int j;
    for (j = 0; j < w.len; j++) queue_request(op, w.b[j], j == w.len - 1);
    if (op == CMD_INSERT) dictionary.push_back(w);
  endtask

  function automatic word_t text_word(string s);
    word_t w;
    int    j;
    w = '0;
    for (j = 0; j < s.len(); j++) w.b[j] = s[j];
    w.len = 5'(s.len());
    return w;
  endfunction

  // Mostly a narrow alphabet so that words share prefixes and queries split.
  function automatic word_t random_word(int lo, int hi, bit wide);
    word_t w;
    int    j;
    w = '0;
    w.len = 5'($urandom_range(hi, lo));
    for (j = 0; j < w.len; j++) begin
      if (wide || $urandom_range(0, 11) == 0) w.b[j] = 8'($urandom);
      else w.b[j] = 8'("a" + $urandom_range(0, 4));
    end
    return w;
  endfunction

  // A query built from dictionary words, with the odd corrupted byte and
  // other requests slipped in between its bytes.
  task automatic queue_split_query();
    int         nw;
    int         k;
    int         j;
    word_t      w;
    logic [7:0] b;
    logic       fin;
    nw = $urandom_range(1, 3);
    for (k = 0; k < nw; k++) begin
      w = dictionary[$urandom_range(0, dictionary.size() - 1)];
      for (j = 0; j < w.len; j++) begin
        fin = (k == nw - 1) && (j == w.len - 1);
        b = w.b[j];
        if ($urandom_range(0, 19) == 0) b = 8'($urandom);
        queue_request(CMD_QUERY, b, fin);
        if (!fin) begin
          if ($urandom_range(0, 24) == 0) queue_word(CMD_INSERT, random_word(1, 3, 1'b0));
          else if ($urandom_range(0, 39) == 0)
            queue_request(CMD_NONE, 8'($urandom), 1'($urandom));
          else if ($urandom_range(0, 59) == 0)
            queue_request(CMD_EMPTY, 8'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // Request driver: holds each request until it is taken, with bursts of idle
  // cycles in some stretches and none near the end.
  int       gap_left = 0;
  bit       idle_mode = 1'b1;
  request_t cur_req;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        predict_request(cur_req);
        n_accepted++;
        if (n_accepted % 50 == 0) idle_mode = $urandom_range(0, 1);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          start <= 1'b0;
        end else if (idle_mode && pending_requests.size() > 30 &&
                     $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 3);
          start <= 1'b0;
        end else begin
          cur_req = pending_requests.pop_front();
          start <= 1'b1;
          cmd <= cur_req.op;
          ch <= cur_req.sym;
          last <= cur_req.fin;
        end
      end
    end
  end

  // Result monitor: every strobe is matched against the oldest answer due.
  answer_t got_due;

  always @(posedge clk) begin
    if (!rst && done) begin
      n_answers++;
      if (segmentable) n_true++;
      if (insert_overflow) n_ovf_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch("result strobe with no answer outstanding");
      end else begin
        got_due = answers_due.pop_front();
        if (segmentable !== got_due.seg)
          report_mismatch($sformatf("segmentable %b, expected %b", segmentable, got_due.seg));
        if (insert_overflow !== got_due.ovf)
          report_mismatch($sformatf("insert_overflow %b, expected %b",
                                    insert_overflow, got_due.ovf));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    word_t w;
    int    r;
    bit    drop_tried;
    drop_tried = 1'b0;

    // Directed part: empty table, extreme bytes, prefixes, abandoned and
    // interleaved queries, a query in the middle of a word, and a dead set.
    queue_request(CMD_EMPTY, 8'h00, 1'b0);
    queue_request(CMD_QUERY, 8'h00, 1'b1);
    queue_request(CMD_INSERT, 8'h00, 1'b1);
    queue_request(CMD_INSERT, 8'hFF, 1'b1);
    queue_request(CMD_QUERY, 8'h00, 1'b0);
    queue_request(CMD_QUERY, 8'hFF, 1'b1);
    queue_word(CMD_INSERT, text_word("ab"));
    queue_word(CMD_QUERY, text_word("ab"));
    queue_word(CMD_QUERY, text_word("a"));
    queue_request(CMD_NONE, 8'hA5, 1'b1);
    queue_request(CMD_QUERY, "a", 1'b0);
    queue_request(CMD_EMPTY, 8'h3C, 1'b1);
    queue_request(CMD_QUERY, "b", 1'b1);
    queue_request(CMD_QUERY, "a", 1'b0);
    queue_word(CMD_INSERT, text_word("q"));
    queue_request(CMD_QUERY, "b", 1'b1);
    queue_request(CMD_INSERT, "x", 1'b0);
    queue_request(CMD_QUERY, "x", 1'b1);
    queue_request(CMD_INSERT, "y", 1'b1);
    dictionary.push_back(text_word("xy"));
    queue_word(CMD_QUERY, text_word("xyab"));
    queue_request(CMD_QUERY, 8'h55, 1'b0);
    queue_request(CMD_QUERY, 8'h00, 1'b0);
    queue_request(CMD_QUERY, 8'h00, 1'b1);

    // Random part. Part way through, wide random words fill the node table so
    // that the later traffic runs against a full table.
    while (n_queued < TARGET_REQUESTS) begin
      if (n_queued >= FILL_AFTER && gen_used < NODES) begin
        queue_word(CMD_INSERT, random_word(8, 12, 1'b1));
      end else if (gen_used == NODES && !drop_tried) begin
        // A word that runs into the full table part way along.
        w = dictionary[$urandom_range(0, dictionary.size() - 1)];
        if (w.len > 5'd13) w.len = 5'd13;
        w.b[w.len] = 8'($urandom);
        w.b[w.len + 5'd1] = 8'($urandom);
        w.len = w.len + 5'd2;
        queue_word(CMD_INSERT, w);
        queue_word(CMD_QUERY, w);
        drop_tried = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 28) queue_word(CMD_INSERT, random_word(1, 4, 1'b0));
        else if (r < 78) queue_split_query();
        else if (r < 88) queue_word(CMD_QUERY, random_word(1, 3, 1'b1));
        else if (r < 94) queue_request(CMD_EMPTY, 8'($urandom), 1'($urandom));
        else queue_request(CMD_NONE, 8'($urandom), 1'($urandom));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent and answered, then a full table scan to spare.
    while (pending_requests.size() != 0 || start || answers_due.size() != 0)
      @(posedge clk);
    repeat (NODES + 16) @(posedge clk);

    $display("Ran %0d requests: %0d insert bytes, %0d query requests, %0d ignored.",
             n_accepted, n_inserts, n_queries, n_ignored);
    $display("Checked %0d answers, %0d segmentable, %0d with the overflow flag set.",
             n_answers, n_true, n_ovf_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
